// ----- rtl/fsgb_pkg.sv -----
// ----------------------------------------------------------------------------
// Font sheet glyph bounds package
// Widths, codes, types and helpers shared by the glyph bounds block.
// ----------------------------------------------------------------------------
package fsgb_pkg;

    localparam int GRID       = 16;
    localparam int MAX_CELL   = 64;
    localparam int PIXEL_W    = 32;
    localparam int CFG_W      = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int COL_W      = 10;
    localparam int IN_W       = 6;
    localparam int CC_W       = 4;
    localparam int CR_W       = 5;
    localparam int SIZE_W     = 7;
    localparam int CODE_W     = 8;
    localparam int SPACE_W    = 6;
    localparam int DIV_STEPS  = COL_W;
    localparam int RS_CNT_W   = 4;
    localparam int CODE_A     = 65;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(8);

    localparam logic [CFG_IDX_W-1:0] REG_CELL_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_CELL_HEIGHT = CFG_IDX_W'(1);

    localparam logic [CR_W-1:0] CR_A = CR_W'(CODE_A / GRID);
    localparam logic [CC_W-1:0] CC_A = CC_W'(CODE_A % GRID);

    typedef enum logic [1:0] {
        RS_IDLE,
        RS_LOAD,
        RS_DIV,
        RS_STORE
    } rs_state_t;

    typedef enum logic {
        KIND_GLYPH   = 1'b0,
        KIND_METRICS = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t               kind;
        logic [CODE_W-1:0]   code;
        logic [COL_W-1:0]    left_x;
        logic [SIZE_W-1:0]   width;
        logic [SIZE_W-1:0]   top_trim;
        logic [SIZE_W-1:0]   line_advance;
        logic [SPACE_W-1:0]  space_advance;
        logic                last;
    } record_t;

    typedef struct packed {
        logic load;
        logic step;
    } div_ctrl_t;

    function automatic logic [SIZE_W-1:0] eff_size(input logic [CFG_W-1:0] v);
        logic [SIZE_W-1:0] r;
        if (v == '0)
        begin
            r = SIZE_W'(1);
        end
        else if (v > CFG_W'(MAX_CELL))
        begin
            r = SIZE_W'(MAX_CELL);
        end
        else
        begin
            r = SIZE_W'(v);
        end
        return r;
    endfunction

endpackage

// ----- rtl/fsgb_if.sv -----
// ----------------------------------------------------------------------------
// Font sheet glyph bounds channels
// Valid/ready channels for incoming pixels and outgoing records.
// ----------------------------------------------------------------------------
interface fsgb_pixel_if;
    import fsgb_pkg::*;

    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] pixel;
    logic               start_of_sheet;

    modport source (output valid, pixel, start_of_sheet, input ready);
    modport sink   (input valid, pixel, start_of_sheet, output ready);
endinterface

interface fsgb_record_if;
    import fsgb_pkg::*;

    logic               valid;
    logic               ready;
    logic               record_kind;
    logic [CODE_W-1:0]  glyph_code;
    logic [COL_W-1:0]   left_x;
    logic [SIZE_W-1:0]  glyph_width;
    logic [SIZE_W-1:0]  top_trim;
    logic [SIZE_W-1:0]  line_advance;
    logic [SPACE_W-1:0] space_advance;
    logic               last_of_burst;

    modport source (output valid, record_kind, glyph_code, left_x, glyph_width, top_trim,
                    line_advance, space_advance, last_of_burst, input ready);
    modport sink   (input valid, record_kind, glyph_code, left_x, glyph_width, top_trim,
                    line_advance, space_advance, last_of_burst, output ready);
endinterface

// ----- rtl/font_sheet_glyph_bounds_core.sv -----
// ----------------------------------------------------------------------------
// Font sheet glyph bounds core
// Tracks the inked column range of every cell of a 16 by 16 glyph sheet and
// emits glyph records per cell row and a font metrics record per sheet.
//
//   Channel   Dir  Request                           Handshake
//   pixels    in   pixel, start_of_sheet             valid/ready
//   records   out  one glyph or metrics record       valid/ready
//   cfg       in   cell_width, cell_height writes    cfg_we, no wait
//
// One pixel is taken per cycle unless stalled; each pixel passes an input
// register and the cell tracking logic. A completed cell row is copied into
// a snapshot buffer that sends its 16 records (17 on the last cell row) one
// per cycle through the output register while the record channel is ready.
// Besides cell size writes, pixels stall only when another cell row
// completes before the previous burst has drained. A cell size write starts
// a re-derivation of the cell position by the 10-step divider, while pixels
// wait in the input register. Reset needs no clearing pass.
// ----------------------------------------------------------------------------
module font_sheet_glyph_bounds_core (
    input  logic                           clk,
    input  logic                           rst_n,
    fsgb_pixel_if.sink                     pixels,
    fsgb_record_if.source                  records,
    input  logic                           cfg_we,
    input  logic [fsgb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fsgb_pkg::CFG_W-1:0]     cfg_data
);
    import fsgb_pkg::*;

    // Configuration
    logic [CFG_W-1:0]   cw_reg;
    logic [CFG_W-1:0]   ch_reg;
    logic [SIZE_W-1:0]  cw_eff;
    logic [SIZE_W-1:0]  ch_eff;
    logic [SIZE_W-1:0]  cw_m1;
    logic [SIZE_W-1:0]  ch_m1;
    logic [COL_W:0]     sheet_w;

    // Input register
    logic               in_v_reg;
    logic [PIXEL_W-1:0] in_px_reg;
    logic               in_start_reg;
    logic               in_load;

    // Sheet state
    logic [PIXEL_W-1:0] bg_reg;
    logic [PIXEL_W-1:0] bg_next;
    logic [COL_W-1:0]   col_reg;
    logic [COL_W-1:0]   col_next;
    logic [COL_W-1:0]   row_reg;
    logic [COL_W-1:0]   row_next;
    logic [CC_W-1:0]    cc_reg;
    logic [CC_W-1:0]    cc_next;
    logic [IN_W-1:0]    ic_reg;
    logic [IN_W-1:0]    ic_next;
    logic [CR_W-1:0]    cr_reg;
    logic [CR_W-1:0]    cr_next;
    logic [IN_W-1:0]    ir_reg;
    logic [IN_W-1:0]    ir_next;
    logic [GRID-1:0]    ink_reg;
    logic [GRID-1:0]    ink_next;
    logic [IN_W-1:0]    min_reg [GRID];
    logic [IN_W-1:0]    min_next [GRID];
    logic [IN_W-1:0]    max_reg [GRID];
    logic [IN_W-1:0]    max_next [GRID];
    logic [SIZE_W-1:0]  top_reg;
    logic [SIZE_W-1:0]  top_next;
    logic [SIZE_W-1:0]  base_reg;
    logic [SIZE_W-1:0]  base_next;
    logic               done_reg;
    logic               done_next;

    // Pixel processing
    logic               start;
    logic [PIXEL_W-1:0] bg_e;
    logic [COL_W-1:0]   col_e;
    logic [COL_W-1:0]   row_e;
    logic [CC_W-1:0]    cc_e;
    logic [IN_W-1:0]    ic_e;
    logic [CR_W-1:0]    cr_e;
    logic [IN_W-1:0]    ir_e;
    logic [GRID-1:0]    ink_e;
    logic [SIZE_W-1:0]  top_e;
    logic [SIZE_W-1:0]  base_e;
    logic               done_e;
    logic               active;
    logic               hit;
    logic               ic_end;
    logic               ir_end;
    logic               col_wrap;
    logic               last_here;
    logic               advance;
    logic [IN_W-1:0]    sel_min;
    logic [IN_W-1:0]    sel_max;
    logic [IN_W-1:0]    new_min;
    logic [IN_W-1:0]    new_max;
    logic [GRID-1:0]    cell_ink_upd;
    logic [IN_W-1:0]    cell_min_upd [GRID];
    logic [IN_W-1:0]    cell_max_upd [GRID];
    logic [SIZE_W-1:0]  top_upd;
    logic [SIZE_W-1:0]  base_upd;
    logic [COL_W-1:0]   col_wrapped;

    // Snapshot buffer
    logic               buf_busy_reg;
    logic [CR_W-1:0]    buf_cnt_reg;
    logic [GRID-1:0]    buf_ink_reg;
    logic [IN_W-1:0]    buf_min_reg [GRID];
    logic [IN_W-1:0]    buf_max_reg [GRID];
    logic [CC_W-1:0]    buf_cr_reg;
    logic               buf_met_reg;
    logic [SIZE_W-1:0]  buf_top_reg;
    logic [SIZE_W-1:0]  buf_adv_reg;
    logic [SIZE_W-1:0]  buf_cw_reg;
    logic               snap_load;
    logic               buf_release;

    // Emission and output register
    logic               emit_go;
    logic               emit_met;
    logic               emit_final;
    logic [CC_W-1:0]    emit_k;
    logic [COL_W-1:0]   emit_lx_base;
    record_t            emit_rec;
    record_t            out_reg;
    logic               out_valid_reg;

    // Cell position re-derivation
    rs_state_t          rs_state_reg;
    rs_state_t          rs_state_next;
    logic [RS_CNT_W-1:0] rs_cnt_reg;
    logic [RS_CNT_W-1:0] rs_cnt_next;
    div_ctrl_t          div_ctrl;
    logic [COL_W-1:0]   q_col;
    logic [COL_W-1:0]   q_row;
    logic [IN_W-1:0]    r_col;
    logic [IN_W-1:0]    r_row;

    assign cw_eff  = eff_size(cw_reg);
    assign ch_eff  = eff_size(ch_reg);
    assign cw_m1   = cw_eff - SIZE_W'(1);
    assign ch_m1   = ch_eff - SIZE_W'(1);
    assign sheet_w = (COL_W+1)'(cw_eff) * (COL_W+1)'(GRID);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cw_reg <= CFG_RESET;
            ch_reg <= CFG_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_CELL_WIDTH)
            begin
                cw_reg <= cfg_data;
            end
            else if (cfg_index == REG_CELL_HEIGHT)
            begin
                ch_reg <= cfg_data;
            end
        end
    end

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    assign pixels.ready = !in_v_reg || advance;
    assign in_load      = pixels.valid && pixels.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg <= 1'b0;
        end
        else if (in_load)
        begin
            in_v_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_px_reg    <= pixels.pixel;
            in_start_reg <= pixels.start_of_sheet;
        end
    end

    // ------------------------------------------------------------------
    // Pixel processing
    // ------------------------------------------------------------------
    always_comb
    begin
        col_wrapped = ({1'b0, col_reg} >= sheet_w) ? '0 : col_reg;

        start  = in_start_reg;
        bg_e   = start ? in_px_reg : bg_reg;
        col_e  = start ? '0 : col_wrapped;
        row_e  = start ? '0 : row_reg;
        cc_e   = start ? '0 : cc_reg;
        ic_e   = start ? '0 : ic_reg;
        cr_e   = start ? '0 : cr_reg;
        ir_e   = start ? '0 : ir_reg;
        ink_e  = start ? '0 : ink_reg;
        top_e  = start ? ch_eff : top_reg;
        base_e = start ? ch_eff : base_reg;
        done_e = start ? 1'b0 : done_reg;

        active    = !done_e && (cr_e < CR_W'(GRID));
        hit       = active && (in_px_reg != bg_e);
        ic_end    = {1'b0, ic_e} == cw_m1;
        ir_end    = {1'b0, ir_e} == ch_m1;
        col_wrap  = (cc_e == CC_W'(GRID - 1)) && ic_end;
        last_here = active && col_wrap && ir_end;

        sel_min = min_reg[cc_e];
        sel_max = max_reg[cc_e];
        new_min = (!ink_e[cc_e] || ic_e < sel_min) ? ic_e : sel_min;
        new_max = (!ink_e[cc_e] || ic_e > sel_max) ? ic_e : sel_max;

        for (int k = 0; k < GRID; k++)
        begin
            if (hit && cc_e == CC_W'(k))
            begin
                cell_ink_upd[k] = 1'b1;
                cell_min_upd[k] = new_min;
                cell_max_upd[k] = new_max;
            end
            else
            begin
                cell_ink_upd[k] = ink_e[k];
                cell_min_upd[k] = min_reg[k];
                cell_max_upd[k] = max_reg[k];
            end
        end

        top_upd  = (hit && {1'b0, ir_e} < top_e) ? {1'b0, ir_e} : top_e;
        base_upd = (hit && cr_e == CR_A && cc_e == CC_A) ? {1'b0, ir_e} : base_e;
    end

    assign buf_release = emit_go && emit_final;
    assign advance     = in_v_reg && (rs_state_reg == RS_IDLE)
                         && (!last_here || !buf_busy_reg || buf_release);
    assign snap_load   = advance && last_here;

    always_comb
    begin
        bg_next   = bg_reg;
        col_next  = col_reg;
        row_next  = row_reg;
        cc_next   = cc_reg;
        ic_next   = ic_reg;
        cr_next   = cr_reg;
        ir_next   = ir_reg;
        ink_next  = ink_reg;
        min_next  = min_reg;
        max_next  = max_reg;
        top_next  = top_reg;
        base_next = base_reg;
        done_next = done_reg;

        if (rs_state_reg == RS_STORE)
        begin
            cc_next = q_col[CC_W-1:0];
            ic_next = r_col;
            cr_next = (|q_row[COL_W-1:CC_W]) ? CR_W'(GRID) : {1'b0, q_row[CC_W-1:0]};
            ir_next = r_row;
        end

        if (advance)
        begin
            bg_next   = bg_e;
            col_next  = col_e;
            row_next  = row_e;
            cc_next   = cc_e;
            ic_next   = ic_e;
            cr_next   = cr_e;
            ir_next   = ir_e;
            ink_next  = ink_e;
            top_next  = top_e;
            base_next = base_e;
            done_next = done_e;
            if (!active)
            begin
                done_next = 1'b1;
            end
            else
            begin
                ink_next  = cell_ink_upd;
                min_next  = cell_min_upd;
                max_next  = cell_max_upd;
                top_next  = top_upd;
                base_next = base_upd;
                if (last_here)
                begin
                    ink_next = '0;
                    if (cr_e == CR_W'(GRID - 1))
                    begin
                        done_next = 1'b1;
                    end
                end
                ic_next = ic_end ? '0 : ic_e + IN_W'(1);
                cc_next = ic_end ? cc_e + CC_W'(1) : cc_e;
                if (col_wrap)
                begin
                    col_next = '0;
                    row_next = row_e + COL_W'(1);
                    ir_next  = ir_end ? '0 : ir_e + IN_W'(1);
                    cr_next  = ir_end ? cr_e + CR_W'(1) : cr_e;
                end
                else
                begin
                    col_next = col_e + COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bg_reg   <= '0;
            col_reg  <= '0;
            row_reg  <= '0;
            cc_reg   <= '0;
            ic_reg   <= '0;
            cr_reg   <= '0;
            ir_reg   <= '0;
            ink_reg  <= '0;
            top_reg  <= SIZE_W'(CFG_RESET);
            base_reg <= SIZE_W'(CFG_RESET);
            done_reg <= 1'b0;
        end
        else
        begin
            bg_reg   <= bg_next;
            col_reg  <= col_next;
            row_reg  <= row_next;
            cc_reg   <= cc_next;
            ic_reg   <= ic_next;
            cr_reg   <= cr_next;
            ir_reg   <= ir_next;
            ink_reg  <= ink_next;
            top_reg  <= top_next;
            base_reg <= base_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        min_reg <= min_next;
        max_reg <= max_next;
    end

    // ------------------------------------------------------------------
    // Snapshot buffer
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_busy_reg <= 1'b0;
            buf_cnt_reg  <= '0;
        end
        else if (snap_load)
        begin
            buf_busy_reg <= 1'b1;
            buf_cnt_reg  <= '0;
        end
        else if (emit_go)
        begin
            if (emit_final)
            begin
                buf_busy_reg <= 1'b0;
            end
            else
            begin
                buf_cnt_reg <= buf_cnt_reg + CR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (snap_load)
        begin
            buf_ink_reg <= cell_ink_upd;
            buf_min_reg <= cell_min_upd;
            buf_max_reg <= cell_max_upd;
            buf_cr_reg  <= cr_e[CC_W-1:0];
            buf_met_reg <= cr_e == CR_W'(GRID - 1);
            buf_top_reg <= top_upd;
            buf_adv_reg <= (base_upd >= top_upd) ? base_upd - top_upd : '0;
            buf_cw_reg  <= cw_eff;
        end
    end

    // ------------------------------------------------------------------
    // Record emission
    // ------------------------------------------------------------------
    assign emit_go = buf_busy_reg && (!out_valid_reg || records.ready);

    always_comb
    begin
        emit_k       = buf_cnt_reg[CC_W-1:0];
        emit_met     = buf_cnt_reg == CR_W'(GRID);
        emit_final   = emit_met || (buf_cnt_reg == CR_W'(GRID - 1) && !buf_met_reg);
        emit_lx_base = COL_W'(emit_k) * COL_W'(buf_cw_reg);

        emit_rec      = '0;
        emit_rec.last = emit_final;
        if (emit_met)
        begin
            emit_rec.kind          = KIND_METRICS;
            emit_rec.top_trim      = buf_top_reg;
            emit_rec.line_advance  = buf_adv_reg;
            emit_rec.space_advance = buf_cw_reg[SIZE_W-1:1];
        end
        else
        begin
            emit_rec.kind = KIND_GLYPH;
            emit_rec.code = {buf_cr_reg, emit_k};
            if (buf_ink_reg[emit_k])
            begin
                emit_rec.left_x = emit_lx_base + COL_W'(buf_min_reg[emit_k]);
                emit_rec.width  = SIZE_W'(buf_max_reg[emit_k]) - SIZE_W'(buf_min_reg[emit_k])
                                  + SIZE_W'(1);
            end
            else
            begin
                emit_rec.left_x = emit_lx_base;
                emit_rec.width  = buf_cw_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_go)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (records.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_go)
        begin
            out_reg <= emit_rec;
        end
    end

    assign records.valid         = out_valid_reg;
    assign records.record_kind   = out_reg.kind;
    assign records.glyph_code    = out_reg.code;
    assign records.left_x        = out_reg.left_x;
    assign records.glyph_width   = out_reg.width;
    assign records.top_trim      = out_reg.top_trim;
    assign records.line_advance  = out_reg.line_advance;
    assign records.space_advance = out_reg.space_advance;
    assign records.last_of_burst = out_reg.last;

    // ------------------------------------------------------------------
    // Cell position re-derivation after a cell size write
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rs_state_reg <= RS_IDLE;
            rs_cnt_reg   <= '0;
        end
        else
        begin
            rs_state_reg <= rs_state_next;
            rs_cnt_reg   <= rs_cnt_next;
        end
    end

    always_comb
    begin
        rs_state_next = rs_state_reg;
        rs_cnt_next   = rs_cnt_reg;
        div_ctrl      = '0;
        case (rs_state_reg)
            RS_IDLE:
            begin
                rs_state_next = RS_IDLE;
            end
            RS_LOAD:
            begin
                div_ctrl.load = 1'b1;
                rs_cnt_next   = '0;
                rs_state_next = RS_DIV;
            end
            RS_DIV:
            begin
                div_ctrl.step = 1'b1;
                if (rs_cnt_reg == RS_CNT_W'(DIV_STEPS - 1))
                begin
                    rs_state_next = RS_STORE;
                end
                else
                begin
                    rs_cnt_next = rs_cnt_reg + RS_CNT_W'(1);
                end
            end
            RS_STORE:
            begin
                rs_state_next = RS_IDLE;
            end
            default:
            begin
                rs_state_next = RS_IDLE;
            end
        endcase
        if (cfg_we)
        begin
            rs_state_next = RS_LOAD;
        end
    end

    fsgb_div u_div_col (
        .clk       (clk),
        .ctrl      (div_ctrl),
        .dividend  (col_wrapped),
        .divisor   (cw_eff),
        .quotient  (q_col),
        .remainder (r_col)
    );

    fsgb_div u_div_row (
        .clk       (clk),
        .ctrl      (div_ctrl),
        .dividend  (row_reg),
        .divisor   (ch_eff),
        .quotient  (q_row),
        .remainder (r_row)
    );

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_pos_in_cell: assert property (@(posedge clk) disable iff (!rst_n)
        (rs_state_reg == RS_IDLE) |->
            ({1'b0, ic_reg} < cw_eff) && ({1'b0, ir_reg} < ch_eff)
            && (cr_reg <= CR_W'(GRID)))
        else $error("Cell position is outside the current cell size.");

    a_col_match: assert property (@(posedge clk) disable iff (!rst_n)
        (rs_state_reg == RS_IDLE) |->
            (col_wrapped == COL_W'(cc_reg) * COL_W'(cw_eff) + COL_W'(ic_reg)))
        else $error("Sheet column and cell position disagree.");

    a_burst_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        buf_cnt_reg <= CR_W'(GRID))
        else $error("Burst counter ran past the metrics record.");

    a_glyph_last: assert property (@(posedge clk) disable iff (!rst_n)
        (records.valid && records.record_kind == KIND_GLYPH && records.last_of_burst) |->
            (records.glyph_code[CC_W-1:0] == CC_W'(GRID - 1)))
        else $error("Glyph burst ended before the last cell of the row.");

endmodule

// ----- rtl/fsgb_div.sv -----
// ----------------------------------------------------------------------------
// Font sheet glyph bounds divider
// Restoring divider, one quotient bit per step, used to re-derive the cell
// position of the raster counters after a cell size change.
// ----------------------------------------------------------------------------
module fsgb_div (
    input  logic                        clk,
    input  fsgb_pkg::div_ctrl_t         ctrl,
    input  logic [fsgb_pkg::COL_W-1:0]  dividend,
    input  logic [fsgb_pkg::SIZE_W-1:0] divisor,
    output logic [fsgb_pkg::COL_W-1:0]  quotient,
    output logic [fsgb_pkg::IN_W-1:0]   remainder
);
    import fsgb_pkg::*;

    logic [SIZE_W-1:0] rem_reg;
    logic [SIZE_W-1:0] rem_next;
    logic [COL_W-1:0]  dq_reg;
    logic [COL_W-1:0]  dq_next;
    logic [SIZE_W:0]   trial;
    logic [SIZE_W:0]   diff;
    logic              fits;

    always_comb
    begin
        trial    = {rem_reg, dq_reg[COL_W-1]};
        diff     = trial - {1'b0, divisor};
        fits     = trial >= {1'b0, divisor};
        rem_next = rem_reg;
        dq_next  = dq_reg;
        if (ctrl.load)
        begin
            rem_next = '0;
            dq_next  = dividend;
        end
        else if (ctrl.step)
        begin
            rem_next = fits ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
            dq_next  = {dq_reg[COL_W-2:0], fits};
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dq_reg  <= dq_next;
    end

    assign quotient  = dq_reg;
    assign remainder = rem_reg[IN_W-1:0];

endmodule
